/* hw/rtl/obct_pkg.sv */
package obct_pkg;

  localparam int ANGLE_BITS_DEFAULT = 16;
  localparam int SINE_DEPTH_DEFAULT = 1024;

  localparam int FACTOR_W = 16;
  localparam logic [FACTOR_W-1:0] SIN_FACTOR_RESET = 16'd23170;
  localparam logic [FACTOR_W-1:0] COS_FACTOR_RESET = 16'd23170;

  localparam int REG_INDEX_W = 2;
  localparam logic [REG_INDEX_W-1:0] REG_SIN_FACTOR = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_COS_FACTOR = 2'd1;

  // Quarter-wave sine polynomial coefficients, Q15.
  localparam logic [15:0] POLY_A = 16'd51472;
  localparam logic [15:0] POLY_B = 16'd21167;
  localparam logic [15:0] POLY_C = 16'd2611;
  localparam logic [16:0] SINE_MAX = 17'd32768;
  localparam logic [15:0] QUARTER_TURN = 16'd32768;

  // Corner k is negative in x where bit k of SGN_X_NEG is set, likewise y.
  localparam logic [3:0] SGN_X_NEG = 4'b1001;
  localparam logic [3:0] SGN_Y_NEG = 4'b0011;

  // Corner, normal, product and projection widths.
  localparam int CW = 25;
  localparam int NW = 27;
  localparam int MW = CW + NW;
  localparam int PW = MW + 1;

endpackage

/* hw/rtl/oriented_box_collision_test.sv */
// Overlap test for two oriented rectangles. One word (a pair of rectangles) is taken
// in every cycle at which start is high; busy is always low. The answer appears on
// overlap with done high for one cycle, after eleven register stages: heading phase
// and half extents, four steps of the sine and cosine polynomial with its limit and
// sign, rotation products, corners, edge normals, projections, extremes and the
// final compare. Results come in input order and cannot be held off, so the
// receiver must take every done cycle. SINE_TABLE_DEPTH is taken as a power of two.
// Factor registers are written through cfg_write/cfg_index/cfg_data; the user must
// write them only while idle, which the block does not enforce.
module oriented_box_collision_test #(
  parameter int ANGLE_BITS       = obct_pkg::ANGLE_BITS_DEFAULT,
  parameter int SINE_TABLE_DEPTH = obct_pkg::SINE_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [23:0]                   first_x,
  input  logic signed [23:0]                   first_y,
  input  logic [15:0]                          first_heading,
  input  logic [15:0]                          first_size,
  input  logic signed [23:0]                   second_x,
  input  logic signed [23:0]                   second_y,
  input  logic [15:0]                          second_heading,
  input  logic [15:0]                          second_size,
  output logic                                 done,
  output logic                                 overlap,
  input  logic                                 cfg_write,
  input  logic [obct_pkg::REG_INDEX_W-1:0]     cfg_index,
  input  logic [obct_pkg::FACTOR_W-1:0]        cfg_data
);

  localparam int LD = $clog2(SINE_TABLE_DEPTH);
  localparam int ZS = 17 - LD;
  localparam logic [15:0] HMASK =
    (ANGLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ANGLE_BITS) - 32'd1);
  localparam int CW = obct_pkg::CW;
  localparam int NW = obct_pkg::NW;
  localparam int MW = obct_pkg::MW;
  localparam int PW = obct_pkg::PW;

  logic [obct_pkg::FACTOR_W-1:0] sin_factor;
  logic [obct_pkg::FACTOR_W-1:0] cos_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      sin_factor <= obct_pkg::SIN_FACTOR_RESET;
      cos_factor <= obct_pkg::COS_FACTOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        obct_pkg::REG_SIN_FACTOR: sin_factor <= cfg_data;
        obct_pkg::REG_COS_FACTOR: cos_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [10:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[9:0], start};
    end
  end
  assign done = vld[10];

  logic signed [23:0] cpx [2];
  logic signed [23:0] cpy [2];
  logic [15:0]        head [2];
  logic [15:0]        size [2];
  assign cpx[0] = first_x;
  assign cpx[1] = second_x;
  assign cpy[0] = first_y;
  assign cpy[1] = second_y;
  assign head[0] = first_heading;
  assign head[1] = second_heading;
  assign size[0] = first_size;
  assign size[1] = second_size;

  // Phase: index w = 0 is sine, w = 1 is cosine (a quarter turn ahead).
  logic [15:0] zin [2][2];
  logic [1:0]  qin [2][2];
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      logic [16+LD-1:0] sc;
      logic [LD-1:0]    idx;
      logic [14:0]      z15;
      sc  = {head[r] & HMASK, {LD{1'b0}}} >> ANGLE_BITS;
      idx = sc[LD-1:0];
      z15 = {idx[LD-3:0], {ZS{1'b0}}};
      qin[r][0] = idx[LD-1:LD-2];
      qin[r][1] = idx[LD-1:LD-2] + 2'd1;
      for (int w = 0; w < 2; w++) begin
        zin[r][w] = qin[r][w][0] ? (obct_pkg::QUARTER_TURN - {1'b0, z15}) : {1'b0, z15};
      end
    end
  end

  // Stage 1
  logic [15:0]        z1 [2][2];
  logic [1:0]         q1 [2][2];
  logic [31:0]        hp1 [2][2];
  logic signed [23:0] px1 [2];
  logic signed [23:0] py1 [2];
  logic signed [24:0] dx1, dy1;
  logic [16:0]        rs1;
  always_ff @(posedge clk) begin
    for (int r = 0; r < 2; r++) begin
      for (int w = 0; w < 2; w++) begin
        z1[r][w] <= zin[r][w];
        q1[r][w] <= qin[r][w];
      end
      hp1[r][0] <= 32'(size[r]) * 32'(sin_factor);
      hp1[r][1] <= 32'(size[r]) * 32'(cos_factor);
      px1[r] <= cpx[r];
      py1[r] <= cpy[r];
    end
    dx1 <= 25'(first_x) - 25'(second_x);
    dy1 <= 25'(first_y) - 25'(second_y);
    rs1 <= 17'(first_size) + 17'(second_size);
  end

  // Stage 2
  logic [15:0]        z2 [2][2];
  logic [16:0]        zz2 [2][2];
  logic [1:0]         q2 [2][2];
  logic [17:0]        h2 [2][2];
  logic signed [23:0] px2 [2];
  logic signed [23:0] py2 [2];
  logic [49:0]        dxsq2, dysq2;
  logic [33:0]        rsq2;
  always_ff @(posedge clk) begin
    for (int r = 0; r < 2; r++) begin
      for (int w = 0; w < 2; w++) begin
        z2[r][w]  <= z1[r][w];
        zz2[r][w] <= 17'((32'(z1[r][w]) * 32'(z1[r][w])) >> 15);
        q2[r][w]  <= q1[r][w];
        h2[r][w]  <= 18'((33'(hp1[r][w]) + 33'd16384) >> 15);
      end
      px2[r] <= px1[r];
      py2[r] <= py1[r];
    end
    dxsq2 <= 50'(dx1) * 50'(dx1);
    dysq2 <= 50'(dy1) * 50'(dy1);
    rsq2  <= 34'(rs1) * 34'(rs1);
  end

  // Stage 3
  logic [15:0]        z3 [2][2];
  logic [16:0]        zz3 [2][2];
  logic [14:0]        pa3 [2][2];
  logic [1:0]         q3 [2][2];
  logic [17:0]        h3 [2][2];
  logic signed [23:0] px3 [2];
  logic signed [23:0] py3 [2];
  logic               far3;
  always_ff @(posedge clk) begin
    for (int r = 0; r < 2; r++) begin
      for (int w = 0; w < 2; w++) begin
        z3[r][w]  <= z2[r][w];
        zz3[r][w] <= zz2[r][w];
        pa3[r][w] <= 15'(obct_pkg::POLY_B -
                         16'((32'(obct_pkg::POLY_C) * 32'(zz2[r][w])) >> 15));
        q3[r][w]  <= q2[r][w];
        h3[r][w]  <= h2[r][w];
      end
      px3[r] <= px2[r];
      py3[r] <= py2[r];
    end
    far3 <= (51'(dxsq2) + 51'(dysq2)) > 51'(rsq2);
  end

  // Stage 4
  logic [15:0]        z4 [2][2];
  logic [15:0]        pb4 [2][2];
  logic [1:0]         q4 [2][2];
  logic [17:0]        h4 [2][2];
  logic signed [23:0] px4 [2];
  logic signed [23:0] py4 [2];
  logic               far4;
  always_ff @(posedge clk) begin
    for (int r = 0; r < 2; r++) begin
      for (int w = 0; w < 2; w++) begin
        z4[r][w]  <= z3[r][w];
        pb4[r][w] <= obct_pkg::POLY_A - 16'((32'(pa3[r][w]) * 32'(zz3[r][w])) >> 15);
        q4[r][w]  <= q3[r][w];
        h4[r][w]  <= h3[r][w];
      end
      px4[r] <= px3[r];
      py4[r] <= py3[r];
    end
    far4 <= far3;
  end

  // Stage 5: magnitude, limit and sign of sine and cosine.
  logic signed [16:0] s5 [2][2];
  logic [17:0]        h5 [2][2];
  logic signed [23:0] px5 [2];
  logic signed [23:0] py5 [2];
  logic               far5;
  always_ff @(posedge clk) begin
    for (int r = 0; r < 2; r++) begin
      for (int w = 0; w < 2; w++) begin
        logic [16:0] mag;
        logic [16:0] lim;
        mag = 17'((32'(pb4[r][w]) * 32'(z4[r][w])) >> 15);
        lim = (mag > obct_pkg::SINE_MAX) ? obct_pkg::SINE_MAX : mag;
        s5[r][w] <= q4[r][w][1] ? -$signed(lim) : $signed(lim);
        h5[r][w] <= h4[r][w];
      end
      px5[r] <= px4[r];
      py5[r] <= py4[r];
    end
    far5 <= far4;
  end

  // Stage 6: rotation products hx*cos, hy*sin, hx*sin, hy*cos.
  logic signed [35:0] pa6 [2];
  logic signed [35:0] pb6 [2];
  logic signed [35:0] pc6 [2];
  logic signed [35:0] pd6 [2];
  logic signed [23:0] px6 [2];
  logic signed [23:0] py6 [2];
  logic               far6;
  always_ff @(posedge clk) begin
    for (int r = 0; r < 2; r++) begin
      pa6[r] <= $signed({1'b0, h5[r][0]}) * s5[r][1];
      pb6[r] <= $signed({1'b0, h5[r][1]}) * s5[r][0];
      pc6[r] <= $signed({1'b0, h5[r][0]}) * s5[r][0];
      pd6[r] <= $signed({1'b0, h5[r][1]}) * s5[r][1];
      px6[r] <= px5[r];
      py6[r] <= py5[r];
    end
    far6 <= far5;
  end

  // Stage 7: corners, rounded to nearest (ties upward) and moved to the centre.
  logic signed [CW-1:0] cx7 [2][4];
  logic signed [CW-1:0] cy7 [2][4];
  logic                 far7;
  always_ff @(posedge clk) begin
    for (int r = 0; r < 2; r++) begin
      for (int k = 0; k < 4; k++) begin
        logic signed [36:0] ta, tb, tc, td, rx, ry;
        ta = obct_pkg::SGN_X_NEG[k] ? -37'(pa6[r]) : 37'(pa6[r]);
        tc = obct_pkg::SGN_X_NEG[k] ? -37'(pc6[r]) : 37'(pc6[r]);
        tb = obct_pkg::SGN_Y_NEG[k] ? -37'(pb6[r]) : 37'(pb6[r]);
        td = obct_pkg::SGN_Y_NEG[k] ? -37'(pd6[r]) : 37'(pd6[r]);
        rx = ta - tb + 37'sd16384;
        ry = tc + td + 37'sd16384;
        cx7[r][k] <= CW'(px6[r]) + CW'($signed(rx[36:15]));
        cy7[r][k] <= CW'(py6[r]) + CW'($signed(ry[36:15]));
      end
    end
    far7 <= far6;
  end

  // Stage 8: edge normals; axes 0..3 from the first rectangle, 4..7 from the second.
  logic signed [CW-1:0] cx8 [2][4];
  logic signed [CW-1:0] cy8 [2][4];
  logic signed [NW-1:0] nx8 [8];
  logic signed [NW-1:0] ny8 [8];
  logic                 far8;
  always_ff @(posedge clk) begin
    for (int e = 0; e < 2; e++) begin
      for (int k = 0; k < 4; k++) begin
        nx8[e*4+k] <= NW'(cy7[e][k]) - NW'(cy7[e][(k+1)%4]);
        ny8[e*4+k] <= NW'(cx7[e][(k+1)%4]) - NW'(cx7[e][k]);
        cx8[e][k]  <= cx7[e][k];
        cy8[e][k]  <= cy7[e][k];
      end
    end
    far8 <= far7;
  end

  // Stage 9: projections of every corner on every axis.
  logic signed [PW-1:0] d9 [8][2][4];
  logic                 far9;
  always_ff @(posedge clk) begin
    for (int j = 0; j < 8; j++) begin
      for (int r = 0; r < 2; r++) begin
        for (int c = 0; c < 4; c++) begin
          logic signed [MW-1:0] m1, m2;
          m1 = cx8[r][c] * nx8[j];
          m2 = cy8[r][c] * ny8[j];
          d9[j][r][c] <= PW'(m1) + PW'(m2);
        end
      end
    end
    far9 <= far8;
  end

  // Stage 10: extremes of each rectangle on each axis.
  logic signed [PW-1:0] mn10 [8][2];
  logic signed [PW-1:0] mx10 [8][2];
  logic                 far10;
  always_ff @(posedge clk) begin
    for (int j = 0; j < 8; j++) begin
      for (int r = 0; r < 2; r++) begin
        logic signed [PW-1:0] lo, hi;
        lo = d9[j][r][0];
        hi = d9[j][r][0];
        for (int c = 1; c < 4; c++) begin
          if (d9[j][r][c] < lo) lo = d9[j][r][c];
          if (d9[j][r][c] > hi) hi = d9[j][r][c];
        end
        mn10[j][r] <= lo;
        mx10[j][r] <= hi;
      end
    end
    far10 <= far9;
  end

  // Stage 11: touching intervals count as separated.
  always_ff @(posedge clk) begin
    logic sep;
    sep = far10;
    for (int j = 0; j < 8; j++) begin
      if (mn10[j][0] >= mx10[j][1] || mn10[j][1] >= mx10[j][0]) sep = 1'b1;
    end
    overlap <= !sep;
  end

endmodule
